FILE: src/rrf_pkg.sv
// Shared types and constants for the RGB 3x3 rank filter.
`default_nettype none
package rrf_pkg;

    localparam int WIN_N      = 9;
    localparam int QDEPTH     = 4;
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int COL_W      = 11;
    localparam int ROW_W      = 12;
    localparam int KEY_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

    localparam logic [1:0] MODE_MEDIAN = 2'd0;
    localparam logic [1:0] MODE_MIN    = 2'd1;
    localparam logic [1:0] MODE_MAX    = 2'd2;

    localparam logic [3:0] RANK_MEDIAN = 4'd4;
    localparam logic [3:0] RANK_MIN    = 4'd0;
    localparam logic [3:0] RANK_MAX    = 4'd8;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rrf_pix_t;

    typedef struct packed {
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
        logic       frame_start;
    } rrf_in_t;

    typedef struct packed {
        logic [9:0]  out_x;
        logic [11:0] out_y;
        logic [7:0]  out_blue;
        logic [7:0]  out_green;
        logic [7:0]  out_red;
        logic        frame_done;
    } rrf_out_t;

    typedef struct packed {
        rrf_pix_t [WIN_N-1:0] win;
        logic [9:0]           x;
        logic [11:0]          y;
        logic                 done;
    } rrf_job_t;

    function automatic logic [KEY_W-1:0] pix_key(input rrf_pix_t p);
        pix_key = KEY_W'(p.red) + KEY_W'(p.green) + KEY_W'(p.blue);
    endfunction

endpackage
`default_nettype wire

FILE: src/rrf_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module rrf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: src/rrf_front.sv
// Front end: position counters, line stores and the 3x3 window.
`default_nettype none
module rrf_front import rrf_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire rrf_in_t                 in_data,
    input  wire logic [COL_W-1:0]        cfg_width,
    input  wire logic [ROW_W:0]          cfg_height,
    input  wire logic [QCNT_W-1:0]       q_level,
    output logic                         push,
    output rrf_job_t                     push_job
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic             acc;
    logic [COL_W-1:0] x_reg, x_next, x_cur, wlast;
    logic [ROW_W-1:0] y_reg, y_next, y_cur, hlast;
    logic [AW-1:0]    idx;
    logic             emit, done;

    logic             b_v_reg;
    logic [AW-1:0]    b_idx_reg;
    rrf_pix_t         b_px_reg;
    logic             b_emit_reg, b_done_reg;
    logic [9:0]       b_x_reg;
    logic [11:0]      b_y_reg;
    logic             fwd_reg, fwd_next;
    rrf_pix_t         fwd_up_reg, fwd_lo_reg;

    rrf_pix_t         ram_up, ram_lo, up_eff, lo_eff;
    rrf_pix_t [WIN_N-1:0] win_reg, win_next;

    assign in_stall = (32'(q_level) + 32'(b_v_reg)) >= QDEPTH;
    assign acc      = in_valid && !in_stall;

    always_comb
    begin
        if (cfg_width < COL_W'(3))
            wlast = COL_W'(2);
        else if (32'(cfg_width) > MAX_WIDTH)
            wlast = COL_W'(MAX_WIDTH - 1);
        else
            wlast = cfg_width - COL_W'(1);
        if (cfg_height < (ROW_W+1)'(3))
            hlast = ROW_W'(2);
        else if (cfg_height > (ROW_W+1)'(4096))
            hlast = ROW_W'(4095);
        else
            hlast = ROW_W'(cfg_height - (ROW_W+1)'(1));
    end

    always_comb
    begin
        x_cur = in_data.frame_start ? '0 : x_reg;
        y_cur = in_data.frame_start ? '0 : y_reg;
        if (32'(x_cur) < MAX_WIDTH)
            idx = AW'(x_cur);
        else
            idx = AW'(MAX_WIDTH - 1);
        emit = (x_cur >= COL_W'(2)) && (y_cur >= ROW_W'(2)) &&
               (x_cur <= wlast) && (y_cur <= hlast);
        done = (x_cur == wlast) && (y_cur == hlast);
        if (x_cur >= wlast)
        begin
            x_next = '0;
            y_next = (y_cur >= hlast) ? '0 : y_cur + ROW_W'(1);
        end
        else
        begin
            x_next = x_cur + COL_W'(1);
            y_next = y_cur;
        end
        fwd_next = b_v_reg && (b_idx_reg == idx);
    end

    rrf_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_upper (
        .clk   (clk),
        .we    (b_v_reg),
        .waddr (b_idx_reg),
        .wdata (lo_eff),
        .re    (acc),
        .raddr (idx),
        .rdata (ram_up)
    );

    rrf_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_lower (
        .clk   (clk),
        .we    (b_v_reg),
        .waddr (b_idx_reg),
        .wdata (b_px_reg),
        .re    (acc),
        .raddr (idx),
        .rdata (ram_lo)
    );

    always_comb
    begin
        up_eff   = fwd_reg ? fwd_up_reg : ram_up;
        lo_eff   = fwd_reg ? fwd_lo_reg : ram_lo;
        win_next = win_reg;
        for (int r = 0; r < 3; r++)
        begin
            win_next[r*3]   = win_reg[r*3+1];
            win_next[r*3+1] = win_reg[r*3+2];
        end
        win_next[2] = up_eff;
        win_next[5] = lo_eff;
        win_next[8] = b_px_reg;
    end

    assign push          = b_v_reg && b_emit_reg;
    assign push_job.win  = win_next;
    assign push_job.x    = b_x_reg;
    assign push_job.y    = b_y_reg;
    assign push_job.done = b_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg   <= '0;
            y_reg   <= '0;
            b_v_reg <= 1'b0;
            win_reg <= '0;
        end
        else
        begin
            b_v_reg <= acc;
            if (acc)
            begin
                x_reg <= x_next;
                y_reg <= y_next;
            end
            if (b_v_reg)
            begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            b_idx_reg  <= idx;
            b_px_reg   <= '{red: in_data.in_red, green: in_data.in_green,
                            blue: in_data.in_blue};
            b_emit_reg <= emit;
            b_done_reg <= done;
            b_x_reg    <= 10'(x_cur - COL_W'(1));
            b_y_reg    <= 12'(y_cur - ROW_W'(1));
            fwd_reg    <= fwd_next;
            fwd_up_reg <= lo_eff;
            fwd_lo_reg <= b_px_reg;
        end
    end

endmodule
`default_nettype wire

FILE: src/rrf_queue.sv
// Small FIFO of window jobs between front and back ends.
`default_nettype none
module rrf_queue import rrf_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire rrf_job_t          push_job,
    input  wire logic              pop,
    output logic                   avail,
    output rrf_job_t               head,
    output logic [QCNT_W-1:0]      level
);

    localparam int PW = $clog2(QDEPTH);

    rrf_job_t          mem_reg [QDEPTH];
    logic [PW-1:0]     wp_reg, rp_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign avail = cnt_reg != '0;
    assign head  = mem_reg[rp_reg];
    assign level = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + PW'(1);
            if (pop)
                rp_reg <= rp_reg + PW'(1);
            cnt_reg <= cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_job;
    end

endmodule
`default_nettype wire

FILE: src/rrf_back.sv
// Back end: key sums, stable rank count and selection into the output register.
`default_nettype none
module rrf_back import rrf_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     avail,
    input  wire rrf_job_t head,
    output logic          pop,
    input  wire logic [1:0] cfg_mode,
    output logic          out_valid,
    input  wire logic     out_stall,
    output rrf_out_t      out_data
);

    logic                       s1_v_reg;
    rrf_job_t                   s1_job_reg;
    logic [WIN_N-1:0][KEY_W-1:0] s1_key_reg;
    logic                       o_v_reg;
    rrf_out_t                   o_reg;
    logic                       o_adv, s1_adv;
    logic [3:0]                 target;
    logic [3:0]                 rank [WIN_N];
    rrf_pix_t                   sel;

    assign o_adv     = !o_v_reg || !out_stall;
    assign s1_adv    = !s1_v_reg || o_adv;
    assign pop       = avail && s1_adv;
    assign out_valid = o_v_reg;
    assign out_data  = o_reg;

    always_comb
    begin
        case (cfg_mode)
            MODE_MIN: target = RANK_MIN;
            MODE_MAX: target = RANK_MAX;
            default:  target = RANK_MEDIAN;
        endcase
        sel = s1_job_reg.win[4];
        for (int i = 0; i < WIN_N; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < WIN_N; j++)
            begin
                if ((s1_key_reg[j] < s1_key_reg[i]) ||
                    ((s1_key_reg[j] == s1_key_reg[i]) && (j < i)))
                    rank[i] = rank[i] + 4'd1;
            end
        end
        for (int i = WIN_N - 1; i >= 0; i--)
        begin
            if (rank[i] == target)
                sel = s1_job_reg.win[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_v_reg <= avail;
            if (o_adv)
                o_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_job_reg <= head;
            for (int i = 0; i < WIN_N; i++)
                s1_key_reg[i] <= pix_key(head.win[i]);
        end
        if (o_adv && s1_v_reg)
        begin
            o_reg.out_x      <= s1_job_reg.x;
            o_reg.out_y      <= s1_job_reg.y;
            o_reg.out_blue   <= sel.blue;
            o_reg.out_green  <= sel.green;
            o_reg.out_red    <= sel.red;
            o_reg.frame_done <= s1_job_reg.done;
        end
    end

endmodule
`default_nettype wire

FILE: src/rgb_rank_filter_3x3.sv
// Top level of the RGB 3x3 rank filter (median / minimum / maximum).
//
//  channel | direction | handshake          | word
//  in      | input     | in_valid/in_stall  | rrf_in_t pixel
//  out     | output    | out_valid/out_stall| rrf_out_t filtered pixel
//  cfg     | input     | cfg_write          | cfg_index, cfg_data
//
// One pixel per clock sustained while in_stall and out_stall are low; each item
// goes through line store read, window into job queue, key sum and rank select.
// in_stall rises when the job queue plus the window stage hold 4 words.
// rst_n clears counters, window and pipeline valids; line stores are not cleared.
// Registers reset to width 640, height 480, median mode.
`default_nettype none
module rgb_rank_filter_3x3 import rrf_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire rrf_in_t               in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output rrf_out_t                   out_data,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [COL_W-1:0]  width_reg;
    logic [ROW_W:0]    height_reg;
    logic [1:0]        mode_reg;
    logic              push, pop, avail;
    rrf_job_t          push_job, head;
    logic [QCNT_W-1:0] level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= COL_W'(640);
            height_reg <= (ROW_W+1)'(480);
            mode_reg   <= MODE_MEDIAN;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[COL_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[ROW_W:0];
                REG_MODE:   mode_reg   <= cfg_data[1:0];
                default:    ;
            endcase
        end
    end

    rrf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .cfg_width  (width_reg),
        .cfg_height (height_reg),
        .q_level    (level),
        .push       (push),
        .push_job   (push_job)
    );

    rrf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .avail    (avail),
        .head     (head),
        .level    (level)
    );

    rrf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .avail     (avail),
        .head      (head),
        .pop       (pop),
        .cfg_mode  (mode_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the RGB 3x3 rank filter: directed and random frames.
`default_nettype none
module tb_top;
    import rrf_pkg::*;

    localparam int LS_DEPTH = 1024;
    localparam int CYCLE_LIMIT = 600000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    rrf_in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    rrf_out_t out_data;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    rgb_rank_filter_3x3 dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // filter state mirror
    rrf_pix_t row_above2 [LS_DEPTH];
    rrf_pix_t row_above1 [LS_DEPTH];
    rrf_pix_t win [WIN_N];
    int unsigned col_cnt;
    int unsigned row_cnt;
    int unsigned width_reg;
    int unsigned height_reg;
    logic [1:0] mode_reg;

    rrf_out_t filtered_q [$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned words_sent = 0;
    int unsigned tx_idle = 0;
    int unsigned rx_idle = 0;

    function automatic logic [KEY_W-1:0] luma_sum(rrf_pix_t p);
        return KEY_W'(p.red) + KEY_W'(p.green) + KEY_W'(p.blue);
    endfunction

    function automatic rrf_pix_t rank_select(int unsigned target);
        int unsigned rank;
        for (int i = 0; i < WIN_N; i++)
        begin
            rank = 0;
            for (int j = 0; j < WIN_N; j++)
                if (luma_sum(win[j]) < luma_sum(win[i]) ||
                    (luma_sum(win[j]) == luma_sum(win[i]) && j < i))
                    rank++;
            if (rank == target)
                return win[i];
        end
        return win[4];
    endfunction

    task automatic filter_pixel(rrf_in_t d);
        int unsigned w, h, x, y, idx, target;
        rrf_pix_t px, up, lo, sel;
        rrf_out_t r;
        w = (width_reg < 3) ? 3 : (width_reg > LS_DEPTH) ? LS_DEPTH : width_reg;
        h = (height_reg < 3) ? 3 : (height_reg > 4096) ? 4096 : height_reg;
        px.red = d.in_red;
        px.green = d.in_green;
        px.blue = d.in_blue;
        if (d.frame_start)
        begin
            col_cnt = 0;
            row_cnt = 0;
        end
        x = col_cnt;
        y = row_cnt;
        idx = (x < LS_DEPTH) ? x : LS_DEPTH - 1;
        up = row_above2[idx];
        lo = row_above1[idx];
        row_above2[idx] = lo;
        row_above1[idx] = px;
        for (int k = 0; k < 3; k++)
        begin
            win[k*3] = win[k*3+1];
            win[k*3+1] = win[k*3+2];
        end
        win[2] = up;
        win[5] = lo;
        win[8] = px;
        if (x >= 2 && y >= 2 && x <= w - 1 && y <= h - 1)
        begin
            target = (mode_reg == MODE_MIN) ? RANK_MIN :
                     (mode_reg == MODE_MAX) ? RANK_MAX : RANK_MEDIAN;
            sel = rank_select(target);
            r.out_x = 10'(x - 1);
            r.out_y = 12'(y - 1);
            r.out_blue = sel.blue;
            r.out_green = sel.green;
            r.out_red = sel.red;
            r.frame_done = (x == w - 1 && y == h - 1);
            filtered_q.push_back(r);
        end
        if (x >= w - 1)
        begin
            col_cnt = 0;
            row_cnt = (y >= h - 1) ? 0 : y + 1;
        end
        else
            col_cnt = x + 1;
    endtask

    task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] rd, logic fs);
        rrf_in_t d;
        d.in_blue = b;
        d.in_green = g;
        d.in_red = rd;
        d.frame_start = fs;
        while ($urandom_range(99) < tx_idle)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= d;
        do @(posedge clk); while (in_stall);
        filter_pixel(d);
        words_sent++;
    endtask

    task automatic send_rand(logic fs);
        send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255), fs);
    endtask

    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        wait (filtered_q.size() == 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        @(posedge clk);
        case (idx)
            REG_WIDTH:  width_reg = val & 'h7ff;
            REG_HEIGHT: height_reg = val & 'h1fff;
            default:    mode_reg = 2'(val);
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_frame(int unsigned w, int unsigned h, int unsigned m);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_MODE, m);
    endtask

    task automatic send_frame(int unsigned n, logic fs);
        for (int i = 0; i < n; i++)
            send_rand(fs && i == 0);
    endtask

    // every mode on 3x3 frames: extremes, and equal keys for the stable tie order
    task automatic test_modes;
        for (int m = 0; m < 4; m++)
        begin
            set_frame(3, 3, m);
            send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
            send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
            send_pixel(8'hff, 8'h00, 8'h00, 1'b0);
            send_pixel(8'h00, 8'hff, 8'h00, 1'b0);
            send_pixel(8'h00, 8'h00, 8'hff, 1'b0);
            send_pixel(8'h55, 8'haa, 8'h00, 1'b0);
            send_pixel(8'haa, 8'h00, 8'h55, 1'b0);
            send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
            send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
            drain();
        end
    endtask

    // a full 64-wide frame fills every line store column the later frames use
    task automatic test_sizes;
        set_frame(0, 1, MODE_MEDIAN);
        send_frame(9, 1'b1);
        send_frame(9, 1'b0);
        drain();
        set_frame(64, 3, MODE_MAX);
        send_frame(3 * 64, 1'b1);
        drain();
        set_frame(2047, 3, MODE_MAX);
        send_frame(12, 1'b1);
        drain();
        set_frame(3, 8191, MODE_MIN);
        send_frame(30, 1'b1);
        send_frame(12, 1'b1);
        drain();
        set_frame(1024, 4096, MODE_MEDIAN);
        send_frame(10, 1'b1);
        drain();
    endtask

    task automatic test_shrink;
        set_frame(10, 10, MODE_MEDIAN);
        send_frame(35, 1'b1);
        drain();
        write_reg(REG_WIDTH, 6);
        write_reg(REG_HEIGHT, 5);
        send_frame(60, 1'b0);
        drain();
    endtask

    task automatic test_random(int unsigned quota);
        int unsigned w, h, stop;
        stop = words_sent + quota;
        while (words_sent < stop)
        begin
            if ($urandom_range(15) == 0)
                w = $urandom_range(3, 64);
            else
                w = $urandom_range(3, 16);
            h = $urandom_range(3, 10);
            set_frame(w, h, $urandom_range(3));
            for (int i = 0; i < w * h; i++)
                send_rand((i == 0) ? 1'($urandom_range(1)) : ($urandom_range(199) == 0));
            if ($urandom_range(3) == 0)
                drain();
            else
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                wait (filtered_q.size() == 0);
                repeat (10) @(posedge clk);
            end
        end
    endtask

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < rx_idle);

    always @(posedge clk)
    begin
        rrf_out_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (filtered_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %p", out_data);
            end
            else
            begin
                e = filtered_q.pop_front();
                if (out_data.out_x !== e.out_x || out_data.out_y !== e.out_y ||
                    out_data.out_blue !== e.out_blue || out_data.out_green !== e.out_green ||
                    out_data.out_red !== e.out_red || out_data.frame_done !== e.frame_done)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %p act %p", e, out_data);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        col_cnt = 0;
        row_cnt = 0;
        width_reg = 640;
        height_reg = 480;
        mode_reg = MODE_MEDIAN;
        for (int i = 0; i < WIN_N; i++)
            win[i] = '0;
        for (int i = 0; i < LS_DEPTH; i++)
        begin
            row_above2[i] = '0;
            row_above1[i] = '0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        tx_idle = 6;
        rx_idle = 45;
        test_modes();
        test_sizes();
        test_shrink();
        test_random(515);
        tx_idle = 45;
        rx_idle = 6;
        test_random(515);
        tx_idle = 0;
        rx_idle = 0;
        test_random(515);
        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && filtered_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

FILE: rgb_rank_filter_3x3.f
src/rrf_pkg.sv
src/rrf_ram.sv
src/rrf_front.sv
src/rrf_queue.sv
src/rrf_back.sv
src/rgb_rank_filter_3x3.sv
verif/tb_top.sv
